// ----- rtl/cal_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the calendar date counter.
// No dependencies; every other file in rtl/ refers to this package.

package cal_pkg;

    // Default widths of the year register and the day-count register.
    localparam int YEAR_BITS_DEF  = 12;
    localparam int COUNT_BITS_DEF = 16;

    // Operation codes carried in the func field.
    localparam logic [1:0] FN_SET = 2'd0;
    localparam logic [1:0] FN_INC = 2'd1;
    localparam logic [1:0] FN_ADD = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [1:0] ST_BAD_YEAR  = 2'd2;
    localparam logic [1:0] ST_BAD_DAY   = 2'd3;

    // Limits checked on a set operation.
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [11:0] YEAR_MIN  = 12'd1900;
    localparam logic [11:0] YEAR_MAX  = 12'd2100;

    // Date after reset.
    localparam logic [3:0] RST_MONTH = 4'd1;
    localparam logic [4:0] RST_DAY   = 5'd1;
    localparam int         RST_YEAR  = 1900;

    // Input beat.
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [11:0] new_year;
        logic [15:0] day_count;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [11:0] cur_year;
        logic [1:0]  status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an input beat is taken this cycle
        logic step;      // advance the date by one month-sized step
        logic out_load;  // capture the next date into the output register
    } t_cal_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic immediate; // the offered beat finishes without any step
        logic last_step; // the pending step completes the advance
    } t_cal_sts;

    // Length of a month; an out-of-range month reads as 31.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/cal_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the calendar date counter: idle/run sequencing and output valid.
// Depends on cal_pkg.

module cal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  cal_pkg::t_cal_sts i_sts,
    output cal_pkg::t_cal_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;
    logic   w_idle;
    logic   w_run;

    // The output register can take a new beat when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    // An advance beat may be taken while an older result still waits.
    always_comb begin
        w_idle = 1'b0;
        w_run  = 1'b0;
        unique case (r_state)
            S_IDLE:  w_idle = 1'b1;
            S_RUN:   w_run  = 1'b1;
            default: w_idle = 1'b0;
        endcase
    end

    assign o_in_ready = w_idle && (w_out_free || !i_sts.immediate);
    assign w_accept   = i_in_valid && o_in_ready;

    // Commands to the datapath; the last step waits for room at the output.
    always_comb begin
        o_cmd.accept   = w_accept;
        o_cmd.step     = w_run && (!i_sts.last_step || w_out_free);
        o_cmd.out_load = (w_accept && i_sts.immediate)
                       || (w_run && i_sts.last_step && w_out_free);
    end

    // Next state and output valid.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !i_sts.immediate) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.last_step && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/cal_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the calendar date counter: date registers, leap tracking,
// set checking, month stepping and the output register. Depends on cal_pkg.

module cal_dp #(
    parameter int COUNT_BITS = cal_pkg::COUNT_BITS_DEF,
    parameter int YEAR_BITS  = cal_pkg::YEAR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cal_pkg::t_in_item  i_item,
    input  cal_pkg::t_cal_cmd  i_cmd,
    output cal_pkg::t_cal_sts  o_sts,
    output cal_pkg::t_out_item o_out
);

    localparam int CW = (COUNT_BITS > 5) ? COUNT_BITS : 5;

    // Date state, with the year's remainders by 400 and by 100 kept alongside.
    logic [3:0]            r_month, n_month;
    logic [4:0]            r_day, n_day;
    logic [YEAR_BITS-1:0]  r_year, n_year;
    logic [8:0]            r_mod400, n_mod400;
    logic [6:0]            r_mod100, n_mod100;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [1:0]            n_status;
    cal_pkg::t_out_item    r_out;

    logic                  w_leap;
    logic [4:0]            w_len;
    logic [4:0]            w_room;
    logic [CW-1:0]         w_rem_x;
    logic [CW-1:0]         w_room_x;
    logic [CW-1:0]         w_rem_sub;
    logic                  w_last;
    logic [31:0]           w_cnt_ext;
    logic [COUNT_BITS-1:0] w_cnt;

    logic                  w_month_ok;
    logic                  w_year_ok;
    logic                  w_set_leap;
    logic [4:0]            w_set_len;
    logic                  w_day_ok;
    logic [1:0]            w_chk;
    logic [11:0]           w_t400;
    logic [11:0]           w_t100;
    logic [11:0]           w_m400;
    logic [11:0]           w_m100;

    // Leap year by the 400/100/4 rule on the wrapped year.
    assign w_leap = (r_mod400 == 9'd0) || ((r_mod100 != 7'd0) && (r_year[1:0] == 2'b00));

    // Days left in the current month, and whether the remaining count ends here.
    assign w_len     = cal_pkg::days_in(r_month, w_leap);
    assign w_room    = (r_day < w_len) ? (w_len - r_day) : 5'd0;
    assign w_rem_x   = CW'(r_rem);
    assign w_room_x  = CW'(w_room);
    assign w_last    = (w_rem_x <= w_room_x);
    assign w_rem_sub = w_rem_x - w_room_x - CW'(1);

    // Only the low COUNT_BITS bits of the count take part.
    assign w_cnt_ext = {16'd0, i_item.day_count};
    assign w_cnt     = w_cnt_ext[COUNT_BITS-1:0];

    // Checks on a set beat: month first, then year, then day.
    assign w_month_ok = (i_item.new_month != 4'd0) && (i_item.new_month <= cal_pkg::MONTH_MAX);
    assign w_year_ok  = (i_item.new_year >= cal_pkg::YEAR_MIN)
                     && (i_item.new_year <= cal_pkg::YEAR_MAX);
    // Within 1900..2100 the only century years that are not leap are the two ends.
    assign w_set_leap = (i_item.new_year[1:0] == 2'b00)
                     && (i_item.new_year != cal_pkg::YEAR_MIN)
                     && (i_item.new_year != cal_pkg::YEAR_MAX);
    assign w_set_len  = cal_pkg::days_in(i_item.new_month, w_set_leap);
    assign w_day_ok   = (i_item.new_day != 5'd0) && (i_item.new_day <= w_set_len);

    always_comb begin
        if (!w_month_ok) begin
            w_chk = cal_pkg::ST_BAD_MONTH;
        end else if (!w_year_ok) begin
            w_chk = cal_pkg::ST_BAD_YEAR;
        end else if (!w_day_ok) begin
            w_chk = cal_pkg::ST_BAD_DAY;
        end else begin
            w_chk = cal_pkg::ST_OK;
        end
    end

    // Remainders of a valid set year, which lies in 1900..2100.
    assign w_t400 = i_item.new_year - 12'd1600;
    assign w_m400 = (w_t400 >= 12'd400) ? (w_t400 - 12'd400) : w_t400;
    assign w_t100 = i_item.new_year - 12'd1900;
    always_comb begin
        if (w_t100 >= 12'd200) begin
            w_m100 = w_t100 - 12'd200;
        end else if (w_t100 >= 12'd100) begin
            w_m100 = w_t100 - 12'd100;
        end else begin
            w_m100 = w_t100;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.immediate = !((i_item.func == cal_pkg::FN_INC)
                          || ((i_item.func == cal_pkg::FN_ADD) && (w_cnt != '0)));
        o_sts.last_step = w_last;
    end

    // Next date: load on a good set, otherwise one step per step command.
    always_comb begin
        n_month  = r_month;
        n_day    = r_day;
        n_year   = r_year;
        n_mod400 = r_mod400;
        n_mod100 = r_mod100;
        n_rem    = r_rem;
        n_status = cal_pkg::ST_OK;

        if (i_cmd.accept) begin
            case (i_item.func)
                cal_pkg::FN_SET: begin
                    n_status = w_chk;
                    if (w_chk == cal_pkg::ST_OK) begin
                        n_month  = i_item.new_month;
                        n_day    = i_item.new_day;
                        n_year   = YEAR_BITS'(i_item.new_year);
                        n_mod400 = w_m400[8:0];
                        n_mod100 = w_m100[6:0];
                    end
                end
                cal_pkg::FN_INC: n_rem = COUNT_BITS'(1);
                cal_pkg::FN_ADD: n_rem = w_cnt;
                default:         n_rem = r_rem;
            endcase
        end

        if (i_cmd.step) begin
            if (w_last) begin
                n_day = r_day + w_rem_x[4:0];
                n_rem = '0;
            end else begin
                n_rem = w_rem_sub[COUNT_BITS-1:0];
                n_day = 5'd1;
                if (r_month < cal_pkg::MONTH_MAX) begin
                    n_month = r_month + 4'd1;
                end else begin
                    n_month = 4'd1;
                    if (&r_year) begin
                        // The year counter wraps to zero, a leap year.
                        n_year   = '0;
                        n_mod400 = 9'd0;
                        n_mod100 = 7'd0;
                    end else begin
                        n_year   = r_year + YEAR_BITS'(1);
                        n_mod400 = (r_mod400 == 9'd399) ? 9'd0 : (r_mod400 + 9'd1);
                        n_mod100 = (r_mod100 == 7'd99) ? 7'd0 : (r_mod100 + 7'd1);
                    end
                end
            end
        end
    end

    // Date state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month  <= cal_pkg::RST_MONTH;
            r_day    <= cal_pkg::RST_DAY;
            r_year   <= YEAR_BITS'(cal_pkg::RST_YEAR);
            r_mod400 <= 9'd300;
            r_mod100 <= 7'd0;
            r_rem    <= '0;
        end else begin
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_mod400 <= n_mod400;
            r_mod100 <= n_mod100;
            r_rem    <= n_rem;
        end
    end

    // Output register holds the finished beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cur_month <= n_month;
            r_out.cur_day   <= n_day;
            r_out.cur_year  <= n_year[11:0];
            r_out.status    <= n_status;
        end
    end

    assign o_out = r_out;

endmodule

// ----- rtl/calendar_date_counter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the calendar date counter: controller plus datapath.
// Depends on cal_pkg, cal_ctrl and cal_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one operation
//   per beat: set a date, advance one day, or advance by day_count days.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one beat per input beat: the date after the operation and a status.
//   A set, an unused func code, or an add of zero days is finished at the
//   accepting edge; its result is valid in the next cycle.
//   An advance steps through whole months, one month boundary per cycle:
//   the month-stepping loop in the datapath crosses month ends until the
//   remaining count ends inside the current month. One item is in work at
//   a time.
//   The output register parts the two sides: while a result waits, an
//   advance beat is still accepted and worked; a beat that would finish at
//   once, or the last step of an advance, waits until the output drains.
//   Reset (synchronous, active low) sets the date to January 1, 1900 and
//   empties the output register.

module calendar_date_counter_unit #(
    parameter int COUNT_BITS = cal_pkg::COUNT_BITS_DEF,
    parameter int YEAR_BITS  = cal_pkg::YEAR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cal_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cal_pkg::t_out_item o_out_data
);

    cal_pkg::t_cal_cmd w_cmd;
    cal_pkg::t_cal_sts w_sts;

    // Sequencing of accept, month steps and output capture.
    cal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Date registers and arithmetic.
    cal_dp #(
        .COUNT_BITS (COUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out_data)
    );

    // A result beat always carries a well-formed month and a nonzero day.
    a_out_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cur_month != 4'd0)
                     && (o_out_data.cur_month <= cal_pkg::MONTH_MAX)
                     && (o_out_data.cur_day != 5'd0))
        else $error("output date out of range");

    // A beat that finishes at once shows its result in the next cycle.
    a_immediate_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_sts.immediate) |=> o_out_valid)
        else $error("immediate result not presented");

    // While an advance is in work no further beat is taken.
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_sts.immediate) |=> !o_in_ready)
        else $error("input taken during an advance");

    // A month step and an input accept never share a cycle.
    a_step_excludes_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.step && w_cmd.accept))
        else $error("step and accept in the same cycle");

endmodule
